/* rtl/v3a_pkg.sv */
package v3a_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned ROOT_BITS = 33;
  localparam int unsigned RAD_BITS = 2 * ROOT_BITS;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_DOT   = 3'd2,
    OP_CROSS = 3'd3,
    OP_LEN3  = 3'd4,
    OP_NORM3 = 3'd5,
    OP_LEN4  = 3'd6,
    OP_NORM4 = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [3:0][31:0] a;
    logic [2:0][31:0] vec;
    logic [31:0]      scalar;
    logic             sat;
    logic             zl;
  } side_t;

endpackage

/* rtl/v3a_sqrt.sv */
module v3a_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [v3a_pkg::RAD_BITS-1:0]       rad_i,
  input  v3a_pkg::side_t                     side_i,
  output logic                               valid_o,
  output logic [v3a_pkg::ROOT_BITS-1:0]      root_o,
  output v3a_pkg::side_t                     side_o
);

  localparam int unsigned N = v3a_pkg::ROOT_BITS;
  localparam int unsigned RW = N + 2;

  logic [v3a_pkg::RAD_BITS-1:0] rad_q  [N+1];
  logic [RW-1:0]                rem_q  [N+1];
  logic [N-1:0]                 root_q [N+1];
  v3a_pkg::side_t               side_q [N+1];
  logic                         vld_q  [N+1];

  assign rad_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;
  assign vld_q[0]  = valid_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] sh, trial;
    logic          ge;
    assign sh    = {rem_q[k][RW-3:0], rad_q[k][v3a_pkg::RAD_BITS-1 -: 2]};
    assign trial = {root_q[k], 2'b01};
    assign ge    = sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1]  <= {rad_q[k][v3a_pkg::RAD_BITS-3:0], 2'b00};
        rem_q[k+1]  <= ge ? sh - trial : sh;
        root_q[k+1] <= {root_q[k][N-2:0], ge};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[N];
  assign root_o  = root_q[N];
  assign side_o  = side_q[N];

endmodule

/* rtl/v3a_div.sv */
module v3a_div #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [31:0]                num_i,
  input  logic [v3a_pkg::ROOT_BITS-1:0]     den_i,
  output logic signed [31:0]                quo_o
);

  localparam int unsigned Q = FRAC_BITS + 1;
  localparam int unsigned DW = v3a_pkg::ROOT_BITS;
  localparam int unsigned RW = DW + 1;

  logic [RW-1:0] rem_q [Q+1];
  logic          nb_q  [Q+1];
  logic [Q-1:0]  quo_q [Q+1];
  logic [DW-1:0] den_q [Q+1];
  logic          neg_q [Q+1];
  logic [31:0]   mag;

  assign mag      = num_i[31] ? 32'(-num_i) : num_i;
  assign rem_q[0] = RW'(mag[31:1]);
  assign nb_q[0]  = mag[0];
  assign quo_q[0] = '0;
  assign den_q[0] = den_i;
  assign neg_q[0] = num_i[31];

  for (genvar s = 0; s < Q; s++) begin : g_stage
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {rem_q[s][RW-2:0], nb_q[s]};
    assign ge = sh >= {1'b0, den_q[s]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? sh - {1'b0, den_q[s]} : sh;
        nb_q[s+1]  <= 1'b0;
        quo_q[s+1] <= {quo_q[s][Q-2:0], ge};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign quo_o = neg_q[Q] ? -$signed(32'(quo_q[Q])) : $signed(32'(quo_q[Q]));

endmodule

/* rtl/vec3_vector_alu.sv */
// Fixed-point vector unit: add, sub, dot, cross, length and normalize on
// signed Q(32-FRAC_BITS).FRAC_BITS vectors. Fully pipelined, one transaction
// per cycle while out_ready_i does not hold the pipeline; every transaction
// passes the product registers, the 33-stage one-bit-per-stage square root,
// the FRAC_BITS+1-stage per-lane dividers and the output register, whatever
// its operation. The whole pipeline holds while a result waits on out_ready_i.
module vec3_vector_alu #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] a_w_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_x_o,
  output logic signed [31:0] result_y_o,
  output logic signed [31:0] result_z_o,
  output logic signed [31:0] result_w_o,
  output logic signed [31:0] result_scalar_o,
  output logic [1:0]         status_o
);

  localparam int unsigned Q = FRAC_BITS + 1;

  function automatic logic [32:0] sat66(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  logic en;
  logic out_valid_q;
  logic signed [31:0] res_x_q, res_y_q, res_z_q, res_w_q, res_s_q;
  logic [1:0] status_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic signed [31:0] av [4];
  logic signed [31:0] bv [3];
  assign av[0] = a_x_i;
  assign av[1] = a_y_i;
  assign av[2] = a_z_i;
  assign av[3] = a_w_i;
  assign bv[0] = b_x_i;
  assign bv[1] = b_y_i;
  assign bv[2] = b_z_i;

  // stage 1: products, squares and add/sub sums per lane
  logic               s1_valid_q;
  v3a_pkg::op_e       s1_op_q;
  logic [31:0]        s1_a_q  [4];
  logic signed [63:0] s1_dp_q [3];
  logic signed [63:0] s1_cp_q [3];
  logic signed [63:0] s1_cn_q [3];
  logic signed [63:0] s1_sq_q [4];
  logic signed [32:0] s1_as_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= v3a_pkg::op_e'(operation_i);
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (en) begin
        s1_a_q[i]  <= av[i];
        s1_sq_q[i] <= av[i] * av[i];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk_i) begin
      if (en) begin
        s1_dp_q[i] <= av[i] * bv[i];
        s1_cp_q[i] <= av[J] * bv[K];
        s1_cn_q[i] <= av[K] * bv[J];
        if (v3a_pkg::op_e'(operation_i) == v3a_pkg::OP_ADD) begin
          s1_as_q[i] <= 33'(av[i]) + 33'(bv[i]);
        end else begin
          s1_as_q[i] <= 33'(av[i]) - 33'(bv[i]);
        end
      end
    end
  end

  // merge: sums, saturation, radicand
  v3a_pkg::side_t              s2_side;
  logic [v3a_pkg::RAD_BITS-1:0] s2_rad;
  logic signed [65:0]          dot_sum;
  logic signed [65:0]          cr_sum [3];
  logic [32:0]                 as_sat [3];
  logic [32:0]                 cr_sat [3];
  logic [32:0]                 dot_sat;

  assign dot_sum = (66'(s1_dp_q[0]) + 66'(s1_dp_q[1]) + 66'(s1_dp_q[2])) >>> FRAC_BITS;
  assign dot_sat = sat66(dot_sum);

  for (genvar i = 0; i < 3; i++) begin : g_merge
    assign cr_sum[i] = (66'(s1_cp_q[i]) - 66'(s1_cn_q[i])) >>> FRAC_BITS;
    assign cr_sat[i] = sat66(cr_sum[i]);
    assign as_sat[i] = sat66(66'(s1_as_q[i]));
  end

  always_comb begin
    s2_rad = 66'(s1_sq_q[0][62:0]) + 66'(s1_sq_q[1][62:0]) + 66'(s1_sq_q[2][62:0]);
    if (s1_op_q == v3a_pkg::OP_LEN4 || s1_op_q == v3a_pkg::OP_NORM4) begin
      s2_rad = s2_rad + 66'(s1_sq_q[3][62:0]);
    end
    s2_side.op     = s1_op_q;
    s2_side.zl     = 1'b0;
    s2_side.scalar = '0;
    s2_side.sat    = 1'b0;
    s2_side.vec    = '0;
    for (int i = 0; i < 4; i++) begin
      s2_side.a[i] = s1_a_q[i];
    end
    case (s1_op_q)
      v3a_pkg::OP_ADD, v3a_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          s2_side.vec[i] = as_sat[i][31:0];
        end
        s2_side.sat = as_sat[0][32] | as_sat[1][32] | as_sat[2][32];
      end
      v3a_pkg::OP_DOT: begin
        s2_side.scalar = dot_sat[31:0];
        s2_side.sat    = dot_sat[32];
      end
      v3a_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          s2_side.vec[i] = cr_sat[i][31:0];
        end
        s2_side.sat = cr_sat[0][32] | cr_sat[1][32] | cr_sat[2][32];
      end
      default: begin
      end
    endcase
  end

  logic                          sq_valid;
  logic [v3a_pkg::ROOT_BITS-1:0] sq_root;
  v3a_pkg::side_t                sq_side;

  v3a_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q),
    .rad_i   (s2_rad),
    .side_i  (s2_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // length result and zero-length flag before the divider lanes
  v3a_pkg::side_t ln_side;
  always_comb begin
    ln_side = sq_side;
    if (sq_side.op == v3a_pkg::OP_LEN3 || sq_side.op == v3a_pkg::OP_LEN4) begin
      if (sq_root[32] || sq_root[31]) begin
        ln_side.scalar = 32'h7fff_ffff;
        ln_side.sat    = 1'b1;
      end else begin
        ln_side.scalar = sq_root[31:0];
      end
    end
    ln_side.zl = (sq_root == '0);
  end

  logic signed [31:0] quo [4];
  for (genvar i = 0; i < 4; i++) begin : g_div
    v3a_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (sq_side.a[i]),
      .den_i (sq_root),
      .quo_o (quo[i])
    );
  end

  v3a_pkg::side_t dl_side_q [Q+1];
  logic           dl_vld_q  [Q+1];
  assign dl_side_q[0] = ln_side;
  assign dl_vld_q[0]  = sq_valid;

  for (genvar s = 0; s < Q; s++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dl_vld_q[s+1] <= 1'b0;
      end else if (en) begin
        dl_vld_q[s+1] <= dl_vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_side_q[s+1] <= dl_side_q[s];
      end
    end
  end

  // output register
  v3a_pkg::side_t fs;
  logic           is_norm;
  assign fs      = dl_side_q[Q];
  assign is_norm = fs.op == v3a_pkg::OP_NORM3 || fs.op == v3a_pkg::OP_NORM4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dl_vld_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (is_norm) begin
        res_x_q  <= fs.zl ? '0 : quo[0];
        res_y_q  <= fs.zl ? '0 : quo[1];
        res_z_q  <= fs.zl ? '0 : quo[2];
        res_w_q  <= (fs.zl || fs.op != v3a_pkg::OP_NORM4) ? '0 : quo[3];
        res_s_q  <= '0;
        status_q <= fs.zl ? v3a_pkg::ST_ZERO : v3a_pkg::ST_OK;
      end else begin
        res_x_q  <= fs.vec[0];
        res_y_q  <= fs.vec[1];
        res_z_q  <= fs.vec[2];
        res_w_q  <= '0;
        res_s_q  <= fs.scalar;
        status_q <= fs.sat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_x_o      = res_x_q;
  assign result_y_o      = res_y_q;
  assign result_z_o      = res_z_q;
  assign result_w_o      = res_w_q;
  assign result_scalar_o = res_s_q;
  assign status_o        = status_q;

endmodule

/* tb/sv/tb_vec3_vector_alu.sv */
`timescale 1ns / 100ps

module tb_vec3_vector_alu;

  localparam int unsigned FB = 16;
  localparam int unsigned LATENCY = FB + 36;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int NUM_RANDOM = 1900;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct {
    v3a_pkg::op_e op;
    logic [31:0]  a [4];
    logic [31:0]  b [3];
  } vec_txn_t;

  typedef struct {
    logic [31:0]      r [4];
    logic [31:0]      sc;
    v3a_pkg::status_e st;
  } vec_res_t;

  typedef struct {
    vec_txn_t txn;
    bit       fixed;
    vec_res_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] operation_i = '0;
  logic signed [31:0] a_x_i = '0, a_y_i = '0, a_z_i = '0, a_w_i = '0;
  logic signed [31:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] result_x_o, result_y_o, result_z_o, result_w_o, result_scalar_o;
  logic [1:0] status_o;

  vec_res_t expected_q [$];
  int unsigned mismatches = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;

  always #4 clk_i = ~clk_i;

  vec3_vector_alu #(.FRAC_BITS(FB)) dut (.*);

  function automatic longint sat32(longint v, inout bit sat);
    if (v > S32_MAX) begin
      sat = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  // exact sum of up to three 64-bit products, floor-shifted by FB and clamped just outside the 32-bit range
  function automatic longint scaled_sum(longint p0, longint p1, longint p2);
    logic signed [66:0] s;
    s = 67'(p0) + 67'(p1) + 67'(p2);
    s = s >>> FB;
    if (s > 67'(S32_MAX)) return S32_MAX + 1;
    if (s < 67'(S32_MIN)) return S32_MIN - 1;
    return longint'(s);
  endfunction

  function automatic logic [32:0] floor_root(logic [65:0] x);
    logic [32:0] res;
    logic [65:0] t;
    res = '0;
    for (int i = 32; i >= 0; i--) begin
      t = {res | (33'd1 << i)} * {res | (33'd1 << i)};
      if (t <= x) res = res | (33'd1 << i);
    end
    return res;
  endfunction

  function automatic vec_res_t predict_vector_op(vec_txn_t t);
    vec_res_t o;
    longint a [4], b [3], v;
    logic [65:0] sq;
    logic [32:0] len;
    bit sat;
    int n;
    sat = 1'b0;
    o.r = '{default: '0};
    o.sc = '0;
    o.st = v3a_pkg::ST_OK;
    for (int i = 0; i < 4; i++) a[i] = longint'(signed'(t.a[i]));
    for (int i = 0; i < 3; i++) b[i] = longint'(signed'(t.b[i]));
    case (t.op)
      v3a_pkg::OP_ADD, v3a_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          v = (t.op == v3a_pkg::OP_ADD) ? a[i] + b[i] : a[i] - b[i];
          o.r[i] = 32'(sat32(v, sat));
        end
      end
      v3a_pkg::OP_DOT:
        o.sc = 32'(sat32(scaled_sum(a[0] * b[0], a[1] * b[1], a[2] * b[2]), sat));
      v3a_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          v = scaled_sum(a[(i + 1) % 3] * b[(i + 2) % 3],
                         -(a[(i + 2) % 3] * b[(i + 1) % 3]), 0);
          o.r[i] = 32'(sat32(v, sat));
        end
      end
      default: begin
        n = (t.op == v3a_pkg::OP_LEN3 || t.op == v3a_pkg::OP_NORM3) ? 3 : 4;
        sq = '0;
        for (int i = 0; i < n; i++) sq += 66'(a[i] * a[i]);
        len = floor_root(sq);
        if (t.op == v3a_pkg::OP_LEN3 || t.op == v3a_pkg::OP_LEN4) begin
          o.sc = (len > 33'(S32_MAX)) ? 32'(S32_MAX) : len[31:0];
          if (len > 33'(S32_MAX)) sat = 1'b1;
        end else if (len == 0) begin
          o.st = v3a_pkg::ST_ZERO;
        end else begin
          for (int i = 0; i < n; i++) o.r[i] = 32'((a[i] * (64'sd1 <<< FB)) / longint'(len));
        end
      end
    endcase
    if (sat) o.st = v3a_pkg::ST_SAT;
    return o;
  endfunction

  function automatic bit same_res(vec_res_t x, vec_res_t y);
    bit eq;
    eq = (x.sc === y.sc) && (x.st === y.st);
    for (int i = 0; i < 4; i++) if (x.r[i] !== y.r[i]) eq = 1'b0;
    return eq;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2 << FB)) - (1 << FB));
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_transaction(vec_txn_t t);
    in_valid_i <= 1'b1;
    operation_i <= t.op;
    a_x_i <= t.a[0];
    a_y_i <= t.a[1];
    a_z_i <= t.a[2];
    a_w_i <= t.a[3];
    b_x_i <= t.b[0];
    b_y_i <= t.b[1];
    b_z_i <= t.b[2];
    do @(posedge clk_i); while (!in_ready_o);
    expected_q = {expected_q, predict_vector_op(t)};
  endtask

  task automatic send_with_gap(vec_txn_t t);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    send_transaction(t);
  endtask

  function automatic vec_txn_t mk(v3a_pkg::op_e op, logic [31:0] ax, logic [31:0] ay,
                                  logic [31:0] az, logic [31:0] aw, logic [31:0] bx,
                                  logic [31:0] by, logic [31:0] bz);
    vec_txn_t t;
    t.op = op;
    t.a = '{ax, ay, az, aw};
    t.b = '{bx, by, bz};
    return t;
  endfunction

  function automatic vec_res_t rs(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic [31:0] w, logic [31:0] sc, v3a_pkg::status_e st);
    vec_res_t o;
    o.r = '{x, y, z, w};
    o.sc = sc;
    o.st = st;
    return o;
  endfunction

  // stimulus
  initial begin
    stim_row_t rows [$];
    vec_txn_t t;
    vec_res_t want;
    localparam logic [31:0] MX = 32'h7fff_ffff, MN = 32'h8000_0000, ONE = 32'h0001_0000;
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_ADD, MX, MN, 1, 0, 1, -1, 2), 1,
                               rs(MX, MN, 3, 0, 0, v3a_pkg::ST_SAT)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_SUB, MN, MX, 5, 0, 1, -1, 2), 1,
                               rs(MN, MX, 3, 0, 0, v3a_pkg::ST_SAT)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_ADD, 1, 2, 3, 9, 4, 5, 6), 1,
                               rs(5, 7, 9, 0, 0, v3a_pkg::ST_OK)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_DOT, MX, MX, MX, 0, MX, MX, MX), 1,
                               rs(0, 0, 0, 0, MX, v3a_pkg::ST_SAT)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_DOT, MN, MN, MN, 0, MX, MX, MX), 1,
                               rs(0, 0, 0, 0, MN, v3a_pkg::ST_SAT)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_DOT, ONE, ONE, ONE, 0, ONE, -ONE, ONE), 1,
                               rs(0, 0, 0, 0, ONE, v3a_pkg::ST_OK)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_DOT, 1, 0, 0, 0, -1, 0, 0), 0, want});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_CROSS, ONE, 0, 0, 0, 0, ONE, 0), 1,
                               rs(0, 0, ONE, 0, 0, v3a_pkg::ST_OK)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_CROSS, MN, MX, MN, 0, MX, MN, MX), 0, want});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_LEN3, 0, 0, 0, 5, 0, 0, 0), 1,
                               rs(0, 0, 0, 0, 0, v3a_pkg::ST_OK)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_LEN3, MN, MN, MN, 0, 0, 0, 0), 1,
                               rs(0, 0, 0, 0, MX, v3a_pkg::ST_SAT)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_LEN4, MN, MN, MN, MN, 0, 0, 0), 1,
                               rs(0, 0, 0, 0, MX, v3a_pkg::ST_SAT)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_LEN4, 0, 0, 0, 3 * ONE, 0, 0, 0), 1,
                               rs(0, 0, 0, 0, 3 * ONE, v3a_pkg::ST_OK)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_LEN3, MX, 0, 0, 0, 0, 0, 0), 1,
                               rs(0, 0, 0, 0, MX, v3a_pkg::ST_OK)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_NORM3, 0, 0, 0, 7, 1, 1, 1), 1,
                               rs(0, 0, 0, 0, 0, v3a_pkg::ST_ZERO)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_NORM4, 0, 0, 0, 0, 1, 1, 1), 1,
                               rs(0, 0, 0, 0, 0, v3a_pkg::ST_ZERO)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_NORM3, 5 * ONE, 0, 0, 0, 0, 0, 0), 1,
                               rs(ONE, 0, 0, 0, 0, v3a_pkg::ST_OK)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_NORM4, 0, 0, 0, -ONE, 0, 0, 0), 1,
                               rs(0, 0, 0, -ONE, 0, v3a_pkg::ST_OK)});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_NORM3, MN, MN, MN, 0, 0, 0, 0), 0, want});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_NORM4, 1, -1, 1, -1, 0, 0, 0), 0, want});
    rows.insert(rows.size(), '{mk(v3a_pkg::OP_NORM4, MX, MN, 1, MX, 0, 0, 0), 0, want});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      if (rows[i].fixed && !same_res(predict_vector_op(rows[i].txn), rows[i].res))
        report_mismatch($sformatf("predictor on directed row %0d", i), 0, 0);
      send_with_gap(rows[i].txn);
    end
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      t.op = v3a_pkg::op_e'($urandom_range(0, 7));
      for (int k = 0; k < 4; k++) t.a[k] = rand_word();
      for (int k = 0; k < 3; k++) t.b[k] = rand_word();
      if ((t.op == v3a_pkg::OP_NORM3 || t.op == v3a_pkg::OP_NORM4) &&
          $urandom_range(0, 9) == 0)
        t.a = '{0, 0, 0, $urandom_range(0, 1) ? 32'd0 : t.a[3]};
      send_with_gap(t);
      if (i == NUM_RANDOM / 2) begin
        in_valid_i <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stalls: some runs without stalls
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    vec_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", result_scalar_o, 0);
      end else begin
        want = expected_q.pop_front();
        if (result_x_o !== want.r[0]) report_mismatch("result_x", result_x_o, want.r[0]);
        if (result_y_o !== want.r[1]) report_mismatch("result_y", result_y_o, want.r[1]);
        if (result_z_o !== want.r[2]) report_mismatch("result_z", result_z_o, want.r[2]);
        if (result_w_o !== want.r[3]) report_mismatch("result_w", result_w_o, want.r[3]);
        if (result_scalar_o !== want.sc)
          report_mismatch("result_scalar", result_scalar_o, want.sc);
        if (status_o !== want.st) report_mismatch("status", 32'(status_o), 32'(want.st));
      end
    end
  end

  initial begin
    @(posedge clk_i);
    while (!(stim_done && expected_q.size() == 0) && cycles < CYCLE_LIMIT) @(posedge clk_i);
    if (cycles < CYCLE_LIMIT) repeat (2 * LATENCY) @(posedge clk_i);
    if (cycles >= CYCLE_LIMIT || mismatches != 0) begin
      $display("CHECKS FAILED");
    end else begin
      $display("ALL CHECKS PASSED");
    end
    $finish;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

endmodule
